FILE: hw/rtl/pdsl_pkg.sv
`default_nettype none

package pdsl_pkg;

   localparam int PEDAL_W  = 14;
   localparam int SAMPLE_W = 12;
   localparam int DUTY_W   = 16;
   localparam int RAMP_W   = 12;
   localparam int FILT_W   = 20;
   localparam int CSR_W    = 16;

   localparam logic [PEDAL_W-1:0] PEDAL_FULL     = 14'd10000;
   localparam logic [DUTY_W-1:0]  FULL_SCALE_RST = 16'd9999;
   localparam logic [RAMP_W-1:0]  RAMP_RST       = 12'd20;

   // pedal * full scale / 10000 as a reciprocal multiply, exact below 2^30
   localparam int TGT_PROD_W = PEDAL_W + DUTY_W;
   localparam int TGT_K      = 44;
   localparam int TGT_RCP_W  = 31;
   localparam int TGT_MUL_W  = TGT_PROD_W + TGT_RCP_W;
   localparam logic [TGT_RCP_W-1:0] TGT_RCP = 31'd1759218605;

   typedef enum logic [0:0] {
      CSR_FULL_SCALE = 1'b0,
      CSR_SLEW_STEP  = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

FILE: hw/rtl/pedal_duty_slew_limiter.sv
`default_nettype none

// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | pedal_hundredths, brake, fault, current_sample
// rsp     | out       | rsp_valid / rsp_ready | duty_out, current_avg
// csr     | in        | csr_wr_en             | csr_index, csr_wdata
//
// one request per cycle unless the response stalls; each is answered once it leaves the last stage
// the path is input register, pedal product, target divide, then slew and filter
// the last stage holds the duty and filter state and drives the response directly
// reset clears duty and average to zero, full scale to 9999 and slew step to 20
// a stalled response freezes the whole pipeline and deasserts req_ready

module pedal_duty_slew_limiter #(
   parameter int SAMPLE_BITS = 12,
   parameter int FRAC_BITS   = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [pdsl_pkg::PEDAL_W-1:0]    req_pedal_hundredths,
   input  wire logic                            req_brake,
   input  wire logic                            req_fault,
   input  wire logic [pdsl_pkg::SAMPLE_W-1:0]   req_current_sample,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [pdsl_pkg::DUTY_W-1:0]          rsp_duty_out,
   output logic [pdsl_pkg::FILT_W-1:0]          rsp_current_avg,
   input  wire logic                            csr_wr_en,
   input  wire logic                            csr_index,
   input  wire logic [pdsl_pkg::CSR_W-1:0]      csr_wdata
);

   import pdsl_pkg::*;

   localparam int SW     = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int SHIFTED_W = SW + FRAC_BITS;
   localparam int SUM_W  = ((SHIFTED_W > FILT_W + 4) ? SHIFTED_W : FILT_W + 4) + 1;
   localparam int FILT_K = SUM_W + 4;
   localparam int RCP_W  = SUM_W + 1;
   localparam int MUL_W  = SUM_W + RCP_W;
   localparam int QUO_W  = MUL_W - FILT_K;
   localparam logic [63:0] FILT_RCP64 = ((64'd1 << FILT_K) + 64'd9) / 64'd10;
   localparam logic [RCP_W-1:0] FILT_RCP = FILT_RCP64[RCP_W-1:0];

   logic                  en;

   logic [DUTY_W-1:0]     full_scale_ff;
   logic [RAMP_W-1:0]     slew_step_ff;

   logic                  s1_valid_ff;
   logic [PEDAL_W-1:0]    s1_pedal_ff;
   logic                  s1_kill_ff;
   logic [SW-1:0]         s1_sample_ff;

   logic                  s2_valid_ff;
   logic [TGT_PROD_W-1:0] s2_prod_ff;
   logic [TGT_PROD_W-1:0] s2_prod_in;
   logic                  s2_full_ff;
   logic                  s2_kill_ff;
   logic [SW-1:0]         s2_sample_ff;

   logic                  s3_valid_ff;
   logic [DUTY_W-1:0]     s3_target_ff;
   logic [DUTY_W-1:0]     s3_target_in;
   logic [TGT_MUL_W-1:0]  tgt_mul;
   logic                  s3_kill_ff;
   logic [SW-1:0]         s3_sample_ff;

   logic                  rsp_valid_ff;
   logic [DUTY_W-1:0]     duty_ff;
   logic [DUTY_W-1:0]     duty_in;
   logic [FILT_W-1:0]     avg_ff;
   logic [FILT_W-1:0]     avg_in;

   logic [DUTY_W:0]       duty_up;
   logic [DUTY_W-1:0]     duty_down;
   logic [SUM_W-1:0]      filt_sum;
   logic [MUL_W-1:0]      filt_mul;
   logic [QUO_W-1:0]      filt_quo;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FULL_SCALE_RST;
         slew_step_ff  <= RAMP_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FULL_SCALE: full_scale_ff <= csr_wdata[DUTY_W-1:0];
            CSR_SLEW_STEP:  slew_step_ff  <= csr_wdata[RAMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // target product and divide
   assign s2_prod_in = TGT_PROD_W'(s1_pedal_ff) * TGT_PROD_W'(full_scale_ff);
   assign tgt_mul    = TGT_MUL_W'(s2_prod_ff) * TGT_MUL_W'(TGT_RCP);

   always_comb begin
      if (s2_full_ff) begin
         s3_target_in = full_scale_ff;
      end else begin
         s3_target_in = tgt_mul[TGT_K +: DUTY_W];
      end
   end

   // slew step
   always_comb begin
      duty_up   = {1'b0, duty_ff} + (DUTY_W + 1)'(slew_step_ff);
      duty_down = (duty_ff > DUTY_W'(slew_step_ff)) ? duty_ff - DUTY_W'(slew_step_ff)
                                                     : '0;
      if (s3_kill_ff) begin
         duty_in = '0;
      end else if (s3_target_ff > duty_ff) begin
         duty_in = (duty_up > {1'b0, s3_target_ff}) ? s3_target_ff : duty_up[DUTY_W-1:0];
      end else if (s3_target_ff < duty_ff) begin
         duty_in = (duty_down < s3_target_ff) ? s3_target_ff : duty_down;
      end else begin
         duty_in = duty_ff;
      end
   end

   // current filter, divide by ten through a reciprocal
   always_comb begin
      filt_sum = (SUM_W'(s3_sample_ff) << FRAC_BITS)
               + (SUM_W'(avg_ff) << 3) + SUM_W'(avg_ff);
      filt_mul = MUL_W'(filt_sum) * MUL_W'(FILT_RCP);
      filt_quo = filt_mul[MUL_W-1:FILT_K];
      if (|filt_quo[QUO_W-1:FILT_W]) begin
         avg_in = '1;
      end else begin
         avg_in = filt_quo[FILT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         duty_ff      <= '0;
         avg_ff       <= '0;
      end else if (en) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
         if (s3_valid_ff) begin
            duty_ff <= duty_in;
            avg_ff  <= avg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pedal_ff  <= req_pedal_hundredths;
         s1_kill_ff   <= req_brake || req_fault;
         s1_sample_ff <= req_current_sample[SW-1:0];
         s2_prod_ff   <= s2_prod_in;
         s2_full_ff   <= s1_pedal_ff >= PEDAL_FULL;
         s2_kill_ff   <= s1_kill_ff;
         s2_sample_ff <= s1_sample_ff;
         s3_target_ff <= s3_target_in;
         s3_kill_ff   <= s2_kill_ff;
         s3_sample_ff <= s2_sample_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty_out    = duty_ff;
   assign rsp_current_avg = avg_ff;

`ifndef SYNTHESIS
   a_kill_zero: assert property (@(posedge clock) disable iff (reset)
      (en && s3_valid_ff && s3_kill_ff) |=> (duty_ff == '0))
      else $error("brake or fault did not clear duty");

   a_slew_bound: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !s3_kill_ff) |->
         (({1'b0, duty_in} <= {1'b0, duty_ff} + (DUTY_W + 1)'(slew_step_ff)) &&
          ({1'b0, duty_in} + (DUTY_W + 1)'(slew_step_ff) >= {1'b0, duty_ff})))
      else $error("duty step exceeds slew step");

   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      (en && s3_valid_ff) |=> rsp_valid_ff)
      else $error("request lost at last stage");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/duty_slew_checker.sv
module duty_slew_checker #(
   parameter int SAMPLE_BITS = 12,
   parameter int FRAC_BITS   = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [pdsl_pkg::PEDAL_W-1:0]    req_pedal_hundredths,
   input  logic                            req_brake,
   input  logic                            req_fault,
   input  logic [pdsl_pkg::SAMPLE_W-1:0]   req_current_sample,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [pdsl_pkg::DUTY_W-1:0]     rsp_duty_out,
   input  logic [pdsl_pkg::FILT_W-1:0]     rsp_current_avg,
   input  logic                            csr_wr_en,
   input  logic                            csr_index,
   input  logic [pdsl_pkg::CSR_W-1:0]      csr_wdata,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pdsl_pkg::*;

   localparam logic [63:0] FILTER_CAP = (64'd1 << FILT_W) - 64'd1;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic [FILT_W-1:0] avg;
   } tick_outcome_type;

   logic [DUTY_W-1:0] full_scale;
   logic [RAMP_W-1:0] slew_step;
   logic [DUTY_W-1:0] duty_now;
   logic [FILT_W-1:0] current_avg;
   tick_outcome_type  tick_outcomes[$];
   int                mismatches = 0;

   // one control tick: filter the current, then slew the duty toward the pedal target or clear it on brake or fault
   function automatic tick_outcome_type advance_tick(input logic [PEDAL_W-1:0]  pedal,
                                                     input logic                brk,
                                                     input logic                flt,
                                                     input logic [SAMPLE_W-1:0] raw);
      logic [63:0]      smp;
      logic [63:0]      avg;
      logic [63:0]      tgt;
      logic [63:0]      duty;
      logic [63:0]      stepped;
      tick_outcome_type res;
      smp = 64'(raw) & ((64'd1 << SAMPLE_BITS) - 64'd1);
      avg = ((smp << FRAC_BITS) + 64'd9 * 64'(current_avg)) / 64'd10;
      if (avg > FILTER_CAP) avg = FILTER_CAP;
      current_avg = avg[FILT_W-1:0];
      duty = 64'(duty_now);
      if (brk || flt) begin
         duty = 64'd0;
      end else begin
         if (pedal >= PEDAL_FULL) tgt = 64'(full_scale);
         else tgt = (64'(pedal) * 64'(full_scale)) / 64'(PEDAL_FULL);
         if (tgt > duty) begin
            stepped = duty + 64'(slew_step);
            duty = (stepped > tgt) ? tgt : stepped;
         end else if (tgt < duty) begin
            stepped = (duty > 64'(slew_step)) ? duty - 64'(slew_step) : 64'd0;
            duty = (stepped < tgt) ? tgt : stepped;
         end
      end
      duty_now = duty[DUTY_W-1:0];
      res.duty = duty_now;
      res.avg  = current_avg;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      tick_outcome_type got;
      tick_outcome_type want;
      if (reset) begin
         tick_outcomes.delete();
         full_scale  = FULL_SCALE_RST;
         slew_step   = RAMP_RST;
         duty_now    = '0;
         current_avg = '0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_FULL_SCALE) full_scale = csr_wdata[DUTY_W-1:0];
            else if (csr_index == CSR_SLEW_STEP) slew_step = csr_wdata[RAMP_W-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            got.duty = rsp_duty_out;
            got.avg  = rsp_current_avg;
            if (tick_outcomes.size() == 0) begin
               if (mismatches < 10)
                  $display("unrequested response: duty %0d avg %0d", got.duty, got.avg);
               mismatches++;
            end else begin
               want = tick_outcomes.pop_front();
               if (got.duty !== want.duty || got.avg !== want.avg) begin
                  if (mismatches < 10)
                     $display("mismatch at %0t: duty exp %0d got %0d, avg exp %0d got %0d",
                              $realtime, want.duty, got.duty, want.avg, got.avg);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            tick_outcomes.push_back(advance_tick(req_pedal_hundredths, req_brake, req_fault,
                                                 req_current_sample));
      end
      fail_count <= mismatches;
      pending    <= tick_outcomes.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pdsl_pkg::*;

   localparam int SAMPLE_BITS   = 12;
   localparam int FRAC_BITS     = 8;
   localparam int SETTLE_CYCLES = 12;
   localparam int IDLE_LIMIT    = 2000;

   logic                clock                = 1'b0;
   logic                reset                = 1'b1;
   logic                req_valid            = 1'b0;
   logic                req_ready;
   logic [PEDAL_W-1:0]  req_pedal_hundredths = '0;
   logic                req_brake            = 1'b0;
   logic                req_fault            = 1'b0;
   logic [SAMPLE_W-1:0] req_current_sample   = '0;
   logic                rsp_valid;
   logic                rsp_ready            = 1'b0;
   logic [DUTY_W-1:0]   rsp_duty_out;
   logic [FILT_W-1:0]   rsp_current_avg;
   logic                csr_wr_en            = 1'b0;
   logic                csr_index            = CSR_FULL_SCALE;
   logic [CSR_W-1:0]    csr_wdata            = '0;
   int                  fail_count;
   int                  pending;
   int                  idle_cycles          = 0;
   int                  burst_left           = 0;
   int                  ready_run            = 0;
   int                  stall_run            = 0;
   bit                  calm                 = 1'b0;

   always #5 clock = ~clock;

   pedal_duty_slew_limiter #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) dut (.*);

   duty_slew_checker #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) checker_i (.*);

   // response side stalls in runs of its own, and never while calm
   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (ready_run > 0) begin
         ready_run <= ready_run - 1;
         rsp_ready <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
         rsp_ready <= 1'b0;
      end else begin
         ready_run <= $urandom_range(0, 24);
         stall_run <= $urandom_range(1, 7);
         rsp_ready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   // one request, then, unless calm, the burst and gap pacing of the sender
   task automatic tick(input logic [PEDAL_W-1:0]  pedal,
                       input logic                brk,
                       input logic                flt,
                       input logic [SAMPLE_W-1:0] smp);
      int gap;
      req_valid            <= 1'b1;
      req_pedal_hundredths <= pedal;
      req_brake            <= brk;
      req_fault            <= flt;
      req_current_sample   <= smp;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if (!calm) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 24);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [CSR_W-1:0] duty_full, input logic [CSR_W-1:0] step);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FULL_SCALE;
      csr_wdata <= duty_full;
      @(posedge clock);
      csr_index <= CSR_SLEW_STEP;
      csr_wdata <= step;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mostly steady pedal runs so the duty can climb, with some noise requests
   task automatic drive_random(input int count);
      int                  done;
      int                  run_len;
      int                  smode;
      int                  k;
      logic [PEDAL_W-1:0]  pedal;
      logic [SAMPLE_W-1:0] smp;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 9) == 0) begin
            tick(PEDAL_W'($urandom), 1'($urandom), 1'($urandom), SAMPLE_W'($urandom));
            done++;
         end else begin
            run_len = $urandom_range(1, 60);
            smode   = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
               0: pedal = PEDAL_W'($urandom_range(0, 16383));
               1: pedal = PEDAL_W'($urandom_range(10000, 16383));
               2: pedal = PEDAL_W'($urandom_range(0, 300));
               default: pedal = PEDAL_W'($urandom_range(9900, 10100));
            endcase
            for (k = 0; k < run_len && done < count; k++) begin
               if (smode == 0) smp = '1;
               else if (smode == 1) smp = '0;
               else smp = SAMPLE_W'($urandom_range(0, 4095));
               tick(pedal, $urandom_range(0, 23) == 0, $urandom_range(0, 23) == 0, smp);
               done++;
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: full scale 9999, step 20
      tick(14'd0,     1'b0, 1'b0, 12'd0);
      tick(14'd16383, 1'b0, 1'b0, 12'd4095);
      tick(14'd10000, 1'b0, 1'b0, 12'd4095);
      tick(14'd9999,  1'b0, 1'b0, 12'd4095);
      tick(14'd51,    1'b0, 1'b0, 12'd4095);
      tick(14'd11,    1'b0, 1'b0, 12'd4095);
      tick(14'd11,    1'b0, 1'b0, 12'd4095);
      tick(14'd16383, 1'b1, 1'b0, 12'd4095);
      tick(14'd16383, 1'b0, 1'b1, 12'd0);
      tick(14'd16383, 1'b1, 1'b1, 12'd0);
      tick(14'd11,    1'b0, 1'b0, 12'd0);
      tick(14'd0,     1'b0, 1'b0, 12'd0);
      tick(14'd10000, 1'b0, 1'b0, 12'd2048);
      tick(14'd0,     1'b0, 1'b0, 12'd4095);
      tick(14'd16383, 1'b0, 1'b0, 12'd4095);
      tick(14'd16383, 1'b0, 1'b0, 12'd4095);
      tick(14'd16383, 1'b0, 1'b0, 12'd4095);
      tick(14'd5000,  1'b0, 1'b0, 12'd1);
      tick(14'd5000,  1'b1, 1'b0, 12'd2730);
      tick(14'd1,     1'b0, 1'b0, 12'd1365);
      tick(14'd9999,  1'b0, 1'b0, 12'd4095);
      tick(14'd9999,  1'b0, 1'b0, 12'd4095);
      drive_random(250);

      drain();
      program_regs(16'hFFFF, 16'd4095);
      drive_random(250);

      drain();
      program_regs(16'd1, 16'd1);
      drive_random(150);

      drain();
      program_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 4095)));
      drive_random(400);

      // upper csr bits set on the ramp write, no idling on either side
      drain();
      program_regs(16'd40000, 16'hF00A);
      calm = 1'b1;
      drive_random(250);
      calm = 1'b0;

      drain();
      program_regs(16'd0, 16'd0);
      drive_random(80);

      drain();
      program_regs(CSR_W'(FULL_SCALE_RST), CSR_W'(RAMP_RST));
      drive_random(150);
      drain();
      drive_random(150);

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
